// ===== rtl/flcr_pkg.sv =====
// Shared constants, types and helper functions for the framed LED command receiver.
package flcr_pkg;

  // Frame buffer depth in bytes; the write index spans 0 .. FRAME_CAPACITY-1.
  localparam int FRAME_CAPACITY = 32;
  localparam int IDX_W          = $clog2(FRAME_CAPACITY);

  localparam int BYTE_W   = 8;
  localparam int CMD_W    = 16;
  localparam int NUM_LEDS = 4;
  localparam int NUM_CODES = 2 * NUM_LEDS;
  localparam int CODE_IDX_W = $clog2(NUM_CODES);
  localparam int CFG_IDX_W  = CODE_IDX_W + 1;

  // Decimal digits sit at frame indices DIGIT_BASE .. DIGIT_BASE+NUM_DIGITS-1.
  localparam int NUM_DIGITS = 4;
  localparam int DIGIT_BASE = 2;

  localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'h43;
  localparam logic [BYTE_W-1:0] HDR_SECOND = 8'h47;
  localparam logic [BYTE_W-1:0] TRL_FIRST  = 8'h53;
  localparam logic [BYTE_W-1:0] TRL_SECOND = 8'h57;
  localparam logic [CMD_W-1:0]  ASCII_ZERO = 16'h0030;

  // Frame event handed from the framer to the command matcher.
  typedef struct packed {
    logic             done;
    logic [CMD_W-1:0] cmd;
  } frame_evt_t;

  // Decimal weight of digit position k, most significant first.
  function automatic logic [CMD_W-1:0] digit_weight(input int k);
    logic [CMD_W-1:0] w;
    unique case (k)
      0:       w = 16'd1000;
      1:       w = 16'd100;
      2:       w = 16'd10;
      default: w = 16'd1;
    endcase
    return w;
  endfunction

  // Weighted contribution of one ASCII byte, modulo 2^16.
  function automatic logic [CMD_W-1:0] digit_term(input int k, input logic [BYTE_W-1:0] b);
    logic [CMD_W-1:0]   d;
    logic [2*CMD_W-1:0] p;
    d = {{(CMD_W-BYTE_W){1'b0}}, b} - ASCII_ZERO;
    p = d * digit_weight(k);
    return p[CMD_W-1:0];
  endfunction

endpackage

// ===== rtl/flcr_framer.sv =====
// Header/trailer tracking, write index and weighted digit store.
module flcr_framer
  import flcr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic [BYTE_W-1:0] byte_i,
  output frame_evt_t        evt_o
);

  logic             hdr_q, hdr_d;
  logic             rcv_q, rcv_d;
  logic             trl_q, trl_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [CMD_W-1:0] term_q [NUM_DIGITS];
  logic [CMD_W-1:0] term_d [NUM_DIGITS];
  logic [CMD_W-1:0] sum;
  logic             done;

  always_comb begin
    hdr_d = hdr_q;
    rcv_d = rcv_q;
    trl_d = trl_q;
    idx_d = idx_q;
    done  = 1'b0;
    for (int k = 0; k < NUM_DIGITS; k++) begin
      term_d[k] = term_q[k];
    end

    // header search runs on every word
    if (!hdr_q && byte_i == HDR_FIRST) begin
      hdr_d = 1'b1;
    end else if (hdr_q && byte_i == HDR_SECOND) begin
      idx_d = IDX_W'(1);
      rcv_d = 1'b1;
    end else begin
      hdr_d = 1'b0;
    end

    if (rcv_d) begin
      // full buffer: drop the frame, store at index 0
      if (idx_d >= IDX_W'(FRAME_CAPACITY - 1)) begin
        trl_d = 1'b0;
        rcv_d = 1'b0;
        idx_d = '0;
      end
      for (int k = 0; k < NUM_DIGITS; k++) begin
        if (idx_d == IDX_W'(DIGIT_BASE + k)) begin
          term_d[k] = digit_term(k, byte_i);
        end
      end
      idx_d = idx_d + IDX_W'(1);

      if (!trl_d && byte_i == TRL_FIRST) begin
        trl_d = 1'b1;
      end else if (trl_d && byte_i == TRL_SECOND) begin
        rcv_d = 1'b0;
        trl_d = 1'b0;
        done  = 1'b1;
      end else begin
        trl_d = 1'b0;
      end
    end

    sum = term_d[0] + term_d[1] + term_d[2] + term_d[3];

    if (done) begin
      idx_d = '0;
      for (int k = 0; k < NUM_DIGITS; k++) begin
        term_d[k] = digit_term(k, '0);
      end
    end
  end

  assign evt_o.done = done;
  assign evt_o.cmd  = done ? sum : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q <= 1'b0;
      rcv_q <= 1'b0;
      trl_q <= 1'b0;
      idx_q <= '0;
      for (int k = 0; k < NUM_DIGITS; k++) begin
        term_q[k] <= digit_term(k, '0);
      end
    end else if (adv_i) begin
      hdr_q <= hdr_d;
      rcv_q <= rcv_d;
      trl_q <= trl_d;
      idx_q <= idx_d;
      for (int k = 0; k < NUM_DIGITS; k++) begin
        term_q[k] <= term_d[k];
      end
    end
  end

endmodule

// ===== rtl/flcr_cmd.sv =====
// Code registers, priority command match and LED state.
module flcr_cmd
  import flcr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CMD_W-1:0]     cfg_data_i,
  input  logic                 adv_i,
  input  frame_evt_t           evt_i,
  output logic [NUM_LEDS-1:0]  led_d_o
);

  logic [CMD_W-1:0]      code_q [NUM_CODES];
  logic [NUM_LEDS-1:0]   led_q, led_d;
  logic [NUM_CODES-1:0]  hit;
  logic                  any_hit;
  logic [CODE_IDX_W-1:0] sel;

  always_comb begin
    for (int k = 0; k < NUM_CODES; k++) begin
      hit[k] = (code_q[k] == evt_i.cmd);
    end
    any_hit = |hit;
    // lowest register index wins
    sel = '0;
    for (int k = NUM_CODES - 1; k >= 0; k--) begin
      if (hit[k]) begin
        sel = CODE_IDX_W'(k);
      end
    end
    led_d = led_q;
    if (evt_i.done && any_hit) begin
      led_d[sel[CODE_IDX_W-1:1]] = ~sel[0];
    end
  end

  assign led_d_o = led_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_CODES; k++) begin
        code_q[k] <= '0;
      end
    end else if (cfg_we_i && cfg_idx_i < CFG_IDX_W'(NUM_CODES)) begin
      code_q[cfg_idx_i[CODE_IDX_W-1:0]] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_q <= '0;
    end else if (adv_i) begin
      led_q <= led_d;
    end
  end

endmodule

// ===== rtl/framed_led_command_receiver.sv =====
// Top level of the framed LED command receiver: input and result registers.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-------------------------------------
//   in      | sink      | in_valid_i / in_ready_o   | rx_byte_i
//   out     | source    | out_valid_o / out_ready_i | led_states_o, frame_done_o,
//           |           |                           | command_value_o
//   cfg     | sink      | cfg_we_i (no wait)        | cfg_idx_i, cfg_data_i
//
// One word per cycle sustained while the out side keeps taking results. A word is
// held in the input register, then one pass of framing, decode and code match
// lands it in the result register; the decode and eight-way compare sit between
// those registers. Reset clears all frame state, the code registers and the LED
// bits; there is no clearing pass. A stall on the out side holds the result
// register and, once the input register is full, holds in_ready_o low.
module framed_led_command_receiver
  import flcr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [BYTE_W-1:0]    rx_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [NUM_LEDS-1:0]  led_states_o,
  output logic                 frame_done_o,
  output logic [CMD_W-1:0]     command_value_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CMD_W-1:0]     cfg_data_i
);

  logic                in_valid_q;
  logic [BYTE_W-1:0]   in_byte_q;
  logic                out_valid_q;
  logic [NUM_LEDS-1:0] led_states_q;
  logic                frame_done_q;
  logic [CMD_W-1:0]    command_value_q;
  logic                advance;
  frame_evt_t          evt;
  logic [NUM_LEDS-1:0] led_next;

  // Move the held word into the result register when that register is free
  // or being emptied this cycle.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // Frame tracking: header and trailer detection, write index, digit store.
  flcr_framer u_framer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (advance),
    .byte_i (in_byte_q),
    .evt_o  (evt)
  );

  // Command matching against the code registers; owns the LED bits.
  flcr_cmd u_cmd (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .adv_i      (advance),
    .evt_i      (evt),
    .led_d_o    (led_next)
  );

  // Input register: take a new word whenever the slot is empty or draining.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // Result register: fill on advance, drop the valid once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      led_states_q <= '0;
    end else if (advance) begin
      out_valid_q  <= 1'b1;
      led_states_q <= led_next;
    end else if (out_ready_i) begin
      out_valid_q  <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      frame_done_q    <= evt.done;
      command_value_q <= evt.cmd;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign led_states_o    = led_states_q;
  assign frame_done_o    = frame_done_q;
  assign command_value_o = command_value_q;

`ifndef SYNTHESIS
  // A result without a completed frame carries no command.
  a_cmd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_done_o |-> command_value_o == '0)
    else $error("command value set without a completed frame");

  // LEDs change only on a completed frame.
  a_led_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !evt.done |-> led_next == led_states_q)
    else $error("LED state changed without a completed frame");

  // A word that advances shows up as a result in the next cycle.
  a_adv_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("advanced word did not reach the result register");
`endif

endmodule

// ===== verif/tb_framed_led_command_receiver.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the framed LED command receiver: random framed traffic vs a predictor.
module tb_framed_led_command_receiver;
  import flcr_pkg::*;

  // Abort threshold, far above the slowest correct run (about 1400 words, each
  // facing at most the longest send gap and the longest receive stall).
  localparam int CYCLE_LIMIT = 1_000_000;
  // Words of random traffic queued per code setting.
  localparam int PHASE_WORDS = 230;

  // Code register indexes, in the order the block decodes them.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CODE_ON_1, REG_CODE_OFF_1, REG_CODE_ON_2, REG_CODE_OFF_2,
    REG_CODE_ON_3, REG_CODE_OFF_3, REG_CODE_ON_4, REG_CODE_OFF_4
  } code_reg_e;

  // How a phase fills the eight code registers.
  typedef enum int {
    PLAN_DIRECTED, PLAN_ZERO, PLAN_ALL_ONES, PLAN_DECIMAL, PLAN_RAW, PLAN_MIXED
  } code_plan_e;

  // Four bytes at frame indices 2..5, entry 0 being the most significant digit.
  typedef logic [NUM_DIGITS-1:0][BYTE_W-1:0] digit_quad_t;

  typedef struct packed {
    logic [NUM_LEDS-1:0] leds;
    logic                done;
    logic [CMD_W-1:0]    cmd;
  } led_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [BYTE_W-1:0]    rx_byte_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [NUM_LEDS-1:0]  led_states_o;
  logic                 frame_done_o;
  logic [CMD_W-1:0]     command_value_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CMD_W-1:0]     cfg_data_i;

  // Stimulus and scoreboard storage.
  logic [BYTE_W-1:0] rx_pending_q[$];
  led_result_t       led_result_q[$];
  led_result_t       got_res;
  led_result_t       want_res;
  int                err_cnt = 0;
  int                cycle_cnt = 0;
  int                in_gap = 0;
  int                out_stall = 0;
  bit                in_fire = 1'b0;
  bit                in_idle_en = 1'b1;
  bit                out_idle_en = 1'b1;

  // Predictor state: mirrors the framer, the digit store and the LED bits.
  logic [CMD_W-1:0]    code_reg [NUM_CODES];
  digit_quad_t         code_digits [NUM_CODES];
  logic                hdr_armed = 1'b0;
  logic                in_frame = 1'b0;
  logic                trl_armed = 1'b0;
  int                  wr_pos = 0;
  digit_quad_t         digit_buf = '0;
  logic [NUM_LEDS-1:0] led_on = '0;

  framed_led_command_receiver u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .led_states_o   (led_states_o),
    .frame_done_o   (frame_done_o),
    .command_value_o(command_value_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Decimal decode of the digit store, wrapping modulo 2^16; non-digits
  // simply contribute negative or oversized terms.
  function automatic logic [CMD_W-1:0] decode_digits(input digit_quad_t d);
    int acc;
    acc = (int'(d[0]) - int'(ASCII_ZERO)) * 1000 + (int'(d[1]) - int'(ASCII_ZERO)) * 100
        + (int'(d[2]) - int'(ASCII_ZERO)) * 10 + (int'(d[3]) - int'(ASCII_ZERO));
    return acc[CMD_W-1:0];
  endfunction

  function automatic digit_quad_t ascii_decimal(input int n);
    digit_quad_t d;
    int w;
    w = 1000;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      d[i] = BYTE_W'(int'(ASCII_ZERO) + (n / w) % 10);
      w = w / 10;
    end
    return d;
  endfunction

  // Advance the predictor by one received byte and return the result word
  // the block should produce for it.
  function automatic led_result_t track_byte(input logic [BYTE_W-1:0] b);
    led_result_t r;
    logic        done;
    logic [CMD_W-1:0] cmd;
    done = 1'b0;
    cmd  = '0;

    // Header search runs on every byte, even inside a frame; a second header
    // byte restarts the frame and keeps the header armed.
    if (!hdr_armed && b == HDR_FIRST) begin
      hdr_armed = 1'b1;
    end else if (hdr_armed && b == HDR_SECOND) begin
      wr_pos   = 1;
      in_frame = 1'b1;
    end else begin
      hdr_armed = 1'b0;
    end

    if (in_frame) begin
      // Full buffer: drop the frame, store this byte at index 0 and carry on
      // with the trailer check regardless.
      if (wr_pos >= FRAME_CAPACITY - 1) begin
        trl_armed = 1'b0;
        in_frame  = 1'b0;
        wr_pos    = 0;
      end
      if (wr_pos >= DIGIT_BASE && wr_pos < DIGIT_BASE + NUM_DIGITS)
        digit_buf[wr_pos - DIGIT_BASE] = b;
      wr_pos++;

      if (!trl_armed && b == TRL_FIRST) begin
        trl_armed = 1'b1;
      end else if (trl_armed && b == TRL_SECOND) begin
        in_frame  = 1'b0;
        trl_armed = 1'b0;
        done      = 1'b1;
      end else begin
        trl_armed = 1'b0;
      end
    end

    if (done) begin
      cmd = decode_digits(digit_buf);
      // First matching register wins; even indexes switch on, odd switch off.
      for (int k = 0; k < NUM_CODES; k++) begin
        if (code_reg[k] == cmd) begin
          led_on[k / 2] = (k % 2 == 0);
          break;
        end
      end
      digit_buf = '0;
      wr_pos    = 0;
    end

    r.leds = led_on;
    r.done = done;
    r.cmd  = cmd;
    return r;
  endfunction

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap(input bit enable);
    int r;
    if (!enable) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Queue a well-formed frame: header, four digit bytes, extra bytes, trailer.
  function automatic int queue_frame(input digit_quad_t d, input int extra);
    rx_pending_q.push_back(HDR_FIRST);
    rx_pending_q.push_back(HDR_SECOND);
    for (int i = 0; i < NUM_DIGITS; i++) rx_pending_q.push_back(d[i]);
    for (int i = 0; i < extra; i++) rx_pending_q.push_back(BYTE_W'($urandom));
    rx_pending_q.push_back(TRL_FIRST);
    rx_pending_q.push_back(TRL_SECOND);
    return NUM_DIGITS + extra + 4;
  endfunction

  // Queue a frame that goes wrong: no trailer, a lone header byte, or a
  // doubled first trailer byte that must not end the frame.
  function automatic int queue_broken_frame();
    int len;
    len = 0;
    case ($urandom_range(0, 2))
      0: begin
        rx_pending_q.push_back(HDR_FIRST);
        rx_pending_q.push_back(HDR_SECOND);
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) rx_pending_q.push_back(BYTE_W'($urandom));
        len += 2;
      end
      1: begin
        rx_pending_q.push_back(HDR_FIRST);
        rx_pending_q.push_back(BYTE_W'($urandom));
        len = 2;
      end
      default: begin
        rx_pending_q.push_back(HDR_FIRST);
        rx_pending_q.push_back(HDR_SECOND);
        for (int i = 0; i < NUM_DIGITS; i++) rx_pending_q.push_back(BYTE_W'($urandom));
        rx_pending_q.push_back(TRL_FIRST);
        rx_pending_q.push_back(TRL_FIRST);
        rx_pending_q.push_back(TRL_SECOND);
        len = NUM_DIGITS + 5;
      end
    endcase
    return len;
  endfunction

  // Queue loose bytes, biased towards the framing values.
  function automatic int queue_noise();
    int len;
    len = $urandom_range(1, 6);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 5))
        0:       rx_pending_q.push_back(HDR_FIRST);
        1:       rx_pending_q.push_back(HDR_SECOND);
        2:       rx_pending_q.push_back(TRL_FIRST);
        3:       rx_pending_q.push_back(TRL_SECOND);
        default: rx_pending_q.push_back(BYTE_W'($urandom));
      endcase
    end
    return len;
  endfunction

  // Mostly frames carrying a configured code, so the LEDs keep moving.
  task automatic queue_traffic(input int budget);
    int n;
    int pick;
    int extra;
    digit_quad_t d;
    n = 0;
    while (n < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        case ($urandom_range(0, 9))
          0:       d = ascii_decimal($urandom_range(0, 9999));
          1:       d = $urandom;
          default: d = code_digits[$urandom_range(0, NUM_CODES - 1)];
        endcase
        // One frame in twenty runs long enough to reach, or hit, the full buffer.
        extra = ($urandom_range(0, 19) == 0) ? $urandom_range(22, 30) : $urandom_range(0, 4);
        n += queue_frame(d, extra);
      end else if (pick < 85) begin
        n += queue_broken_frame();
      end else begin
        n += queue_noise();
      end
    end
  endtask

  // Hold off until no word is waiting, in flight or owed.
  task automatic wait_drained();
    while (rx_pending_q.size() != 0 || in_valid_i || led_result_q.size() != 0)
      @(negedge clk_i);
  endtask

  // One register write per cycle; the caller drops the enable afterwards.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CMD_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    if (idx < NUM_CODES) code_reg[idx] = data;
  endtask

  // Fill all eight codes from digit patterns, so that frames can hit them,
  // then poke an unused index, which the block must ignore.
  task automatic program_codes(input code_plan_e plan);
    digit_quad_t d;
    for (int k = 0; k < NUM_CODES; k++) begin
      case (plan)
        PLAN_DIRECTED: begin
          // The last code repeats the first, so it must never take effect.
          if (k == REG_CODE_OFF_4) d = ascii_decimal(1111);
          else if (k == REG_CODE_ON_4) d = ascii_decimal(9999);
          else d = ascii_decimal(1111 * (k + 1));
        end
        PLAN_ZERO: begin
          d = ascii_decimal(0);
        end
        PLAN_ALL_ONES: begin
          // "000/" decodes to -1, that is 0xFFFF.
          d = ascii_decimal(0);
          d[NUM_DIGITS-1] = ASCII_ZERO[BYTE_W-1:0] - 8'd1;
        end
        PLAN_DECIMAL: begin
          d = ascii_decimal($urandom_range(0, 9999));
        end
        PLAN_RAW: begin
          d = $urandom;
        end
        default: begin
          if (k > 0 && $urandom_range(0, 2) == 0) d = code_digits[$urandom_range(0, k - 1)];
          else if ($urandom_range(0, 1) == 0) d = ascii_decimal($urandom_range(0, 9999));
          else d = $urandom;
        end
      endcase
      code_digits[k] = d;
      write_register(CFG_IDX_W'(k), decode_digits(d));
    end
    write_register(CFG_IDX_W'($urandom_range(NUM_CODES, 2 ** CFG_IDX_W - 1)),
                   CMD_W'($urandom));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Sender: present the next word at the falling edge once the previous one
  // has gone, after its random gap.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (rx_pending_q.size() != 0) begin
        in_valid_i <= 1'b1;
        rx_byte_i  <= rx_pending_q.pop_front();
        in_gap = pick_gap(in_idle_en);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: stall the result side at random.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_stall > 0) begin
        out_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        out_stall = pick_gap(out_idle_en);
      end
    end
  end

  // Scoreboard: check the delivered word against the oldest prediction,
  // then predict for the word accepted at this edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_res.leds = led_states_o;
      got_res.done = frame_done_o;
      got_res.cmd  = command_value_o;
      if (led_result_q.size() == 0) begin
        $error("result word with nothing expected: leds %h done %b cmd %h",
               got_res.leds, got_res.done, got_res.cmd);
        err_cnt++;
      end else begin
        want_res = led_result_q.pop_front();
        if (got_res.leds !== want_res.leds) begin
          $error("led_states: expected %h, got %h", want_res.leds, got_res.leds);
          err_cnt++;
        end
        if (got_res.done !== want_res.done) begin
          $error("frame_done: expected %b, got %b", want_res.done, got_res.done);
          err_cnt++;
        end
        if (got_res.cmd !== want_res.cmd) begin
          $error("command_value: expected %h, got %h", want_res.cmd, got_res.cmd);
          err_cnt++;
        end
      end
    end
    in_fire = rst_ni && in_valid_i && in_ready_o;
    if (in_fire) led_result_q.push_back(track_byte(rx_byte_i));
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL framed_led_command_receiver");
      $finish;
    end
  end

  initial begin
    code_plan_e plans [6];
    plans = '{PLAN_ZERO, PLAN_ALL_ONES, PLAN_DECIMAL, PLAN_RAW, PLAN_MIXED, PLAN_MIXED};
    for (int k = 0; k < NUM_CODES; k++) begin
      code_reg[k]    = '0;
      code_digits[k] = ascii_decimal(0);
    end
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    rx_byte_i   = '0;
    out_ready_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: a plain frame hitting a duplicated code, a repeated first
    // header byte that must not open a frame, a header restart inside a
    // frame, and a frame of non-digit bytes that matches no code.
    program_codes(PLAN_DIRECTED);
    void'(queue_frame(ascii_decimal(1111), 0));
    rx_pending_q.push_back(HDR_FIRST);
    rx_pending_q.push_back(HDR_FIRST);
    rx_pending_q.push_back(HDR_SECOND);
    rx_pending_q.push_back(HDR_FIRST);
    rx_pending_q.push_back(HDR_SECOND);
    void'(queue_frame(ascii_decimal(9999), 0));
    void'(queue_frame({8'hFF, 8'h00, 8'h2F, 8'h3A}, 0));
    wait_drained();

    // Random phases, one code setting each; the sender pauses for a full
    // drain before every reprogramming. Run one phase without any idling.
    foreach (plans[p]) begin
      program_codes(plans[p]);
      in_idle_en  = (plans[p] != PLAN_DECIMAL);
      out_idle_en = (plans[p] != PLAN_DECIMAL) && ($urandom_range(0, 3) != 0);
      queue_traffic(PHASE_WORDS);
      wait_drained();
    end

    // Allow for anything the block might still push out.
    repeat (8) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("PASS framed_led_command_receiver");
    end else begin
      $display("FAIL framed_led_command_receiver");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/flcr_pkg.sv
rtl/flcr_framer.sv
rtl/flcr_cmd.sv
rtl/framed_led_command_receiver.sv
verif/tb_framed_led_command_receiver.sv
